// ===== rtl/core/ffrm_pkg.sv =====
// Shared types, codes and field layout for the first-fit resource map.
package ffrm_pkg;

    localparam int DEF_TABLE_SLOTS = 64;
    localparam int DEF_UNIT_BITS   = 16;

    localparam int FIELD_W      = 16;
    localparam int STATUS_W     = 2;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 24;
    localparam int IN_OP_LSB    = 0;
    localparam int IN_ADDR_LSB  = 1;
    localparam int IN_UNITS_LSB = 17;
    localparam int OUT_BASE_LSB = 0;
    localparam int OUT_STAT_LSB = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LEN = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_ZERO_UNITS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_ALLOC, S_FILL, S_LEFT, S_RIGHT, S_WRITE, S_DONE
    } t_state;

    typedef struct packed {
        logic init;
        logic accept;
        logic alloc_scan;
        logic fill;
        logic left;
        logic right;
        logic write_back;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_zero;
        logic in_free;
        logic scan_done;
        logic alloc_hit;
        logic fill_ok;
        logic fill_fail;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/first_fit_resource_map.sv =====
// Top level of the first-fit resource map allocator.
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid/s_tready    op, addr, units
//  m_*       out        m_tvalid/m_tready    base, status
//  i_cfg_*   in         i_cfg_we             start address, region length
//
// Zero-unit requests go straight to the done state. An allocate makes one scan of the
// table; a free makes a fill pass over the slots and then a left and a right merge scan:
// each scan walks the table one slot a cycle through the single read port of the RAM.
// After reset the init state loads slot zero before the first word is taken.
// A finished result waits in the output register; the next word is taken meanwhile,
// and its own result waits only if the output is still stalled.
module first_fit_resource_map #(
    parameter int TABLE_SLOTS = ffrm_pkg::DEF_TABLE_SLOTS,
    parameter int UNIT_BITS   = ffrm_pkg::DEF_UNIT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ffrm_pkg::IN_TDATA_W-1:0]  s_tdata,  // op, addr[15:0], units[15:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ffrm_pkg::OUT_TDATA_W-1:0] m_tdata,  // base[15:0], status[1:0]
    input  logic                             i_cfg_we,
    input  logic [ffrm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ffrm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ffrm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ffrm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ffrm_dp #(.TABLE_SLOTS(TABLE_SLOTS), .UNIT_BITS(UNIT_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tvalid (s_tvalid),
        .i_s_tdata  (s_tdata),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    assign s_tready = cmd.accept;

    // Once a word is taken the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again straight after a word");

    // Any result other than success carries a zero base.
    a_fail_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[OUT_STAT_LSB +: STATUS_W] != ST_OK)
        |-> (m_tdata[OUT_BASE_LSB +: FIELD_W] == '0))
        else $error("failed request returned a non-zero base");

    // A new result is only loaded while no input word is being taken.
    a_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result loaded while the input side was open");
endmodule

// ===== rtl/core/ffrm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ffrm_ram #(
    parameter int W  = 8,
    parameter int D  = 2,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/ffrm_ctrl.sv =====
// Sequencer for the allocate, slot fill and merge passes.
module ffrm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffrm_pkg::t_stat i_stat,
    output ffrm_pkg::t_cmd  o_cmd
);
    import ffrm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:  n_state = S_IDLE;
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    if (i_stat.in_zero)      n_state = S_DONE;
                    else if (i_stat.in_free) n_state = S_FILL;
                    else                     n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (i_stat.alloc_hit || i_stat.scan_done) n_state = S_DONE;
            end
            S_FILL: begin
                if (i_stat.fill_ok)        n_state = S_LEFT;
                else if (i_stat.fill_fail) n_state = S_DONE;
            end
            S_LEFT: begin
                if (i_stat.scan_done) n_state = S_RIGHT;
            end
            S_RIGHT: begin
                if (i_stat.scan_done) n_state = S_WRITE;
            end
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_INIT:  o_cmd.init       = 1'b1;
            S_IDLE:  o_cmd.accept     = 1'b1;
            S_ALLOC: o_cmd.alloc_scan = 1'b1;
            S_FILL:  o_cmd.fill       = 1'b1;
            S_LEFT:  o_cmd.left       = 1'b1;
            S_RIGHT: o_cmd.right      = 1'b1;
            S_WRITE: o_cmd.write_back = 1'b1;
            S_DONE:  o_cmd.finish     = 1'b1;
            default: o_cmd            = '0;
        endcase
    end
endmodule

// ===== rtl/core/ffrm_dp.sv =====
// Extent table, scan pipeline, merge arithmetic and output register.
module ffrm_dp #(
    parameter int TABLE_SLOTS = ffrm_pkg::DEF_TABLE_SLOTS,
    parameter int UNIT_BITS   = ffrm_pkg::DEF_UNIT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ffrm_pkg::t_cmd                   i_cmd,
    output ffrm_pkg::t_stat                  o_stat,
    input  logic                             i_s_tvalid,
    input  logic [ffrm_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [ffrm_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [ffrm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ffrm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ffrm_pkg::*;

    localparam int UB = UNIT_BITS;
    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    logic [UB-1:0]          r_cfg_start, r_cfg_total;
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [CW-1:0]          r_siu, r_idx;
    logic                   r_ev;
    logic [IW-1:0]          r_ev_idx, r_slot;
    logic [UB-1:0]          r_addr, r_units, r_acc, r_base;
    t_status                r_status;
    logic                   r_out_valid;
    logic [FIELD_W-1:0]     r_out_base;
    t_status                r_out_status;

    logic          in_op;
    logic [UB-1:0] in_addr, in_units;
    logic [UB-1:0] rd_start, rd_len, sat_len, sat_start;
    logic [UB:0]   sum_len, sum_start, end_rd, end_cur;
    logic          cfg_hit, scan_act, scan_done, ev_live, ev_other;
    logic          alloc_hit, left_hit, right_hit;
    logic          fill_here, fill_free_slot, room;
    logic          out_free;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [2*UB-1:0] ram_wdata, ram_rdata;
    logic [UB-1:0] cfg_start_n, cfg_total_n;

    assign in_op    = i_s_tdata[IN_OP_LSB];
    assign in_addr  = UB'(i_s_tdata[IN_ADDR_LSB +: FIELD_W]);
    assign in_units = UB'(i_s_tdata[IN_UNITS_LSB +: FIELD_W]);

    assign cfg_hit = i_cfg_we &&
                     (i_cfg_idx == CFG_START_ADDR || i_cfg_idx == CFG_REGION_LEN);
    assign cfg_start_n = (i_cfg_idx == CFG_START_ADDR) ? UB'(i_cfg_data) : r_cfg_start;
    assign cfg_total_n = (i_cfg_idx == CFG_REGION_LEN) ? UB'(i_cfg_data) : r_cfg_total;

    assign rd_start = ram_rdata[2*UB-1:UB];
    assign rd_len   = ram_rdata[UB-1:0];

    // Sums are one bit wider so that adjacency is tested without wrap.
    assign sum_len   = {1'b0, rd_len} + {1'b0, r_acc};
    assign sum_start = {1'b0, rd_start} + {1'b0, r_units};
    assign end_rd    = {1'b0, rd_start} + {1'b0, rd_len};
    assign end_cur   = {1'b0, r_addr} + {1'b0, r_units};
    assign sat_len   = sum_len[UB]   ? {UB{1'b1}} : sum_len[UB-1:0];
    assign sat_start = sum_start[UB] ? {UB{1'b1}} : sum_start[UB-1:0];

    assign scan_act  = i_cmd.alloc_scan || i_cmd.left || i_cmd.right;
    assign scan_done = !r_ev && (r_idx >= r_siu);
    assign ev_live   = r_ev && r_valid[r_ev_idx];
    assign ev_other  = ev_live && (r_ev_idx != r_slot);
    assign alloc_hit = i_cmd.alloc_scan && ev_live && (rd_len >= r_units);
    assign left_hit  = i_cmd.left && ev_other && (end_rd == {1'b0, r_addr});
    assign right_hit = i_cmd.right && ev_other && (end_cur == {1'b0, rd_start});

    assign fill_here      = r_idx < r_siu;
    assign fill_free_slot = fill_here && !r_valid[r_idx[IW-1:0]];
    assign room           = r_siu < CW'(TABLE_SLOTS);

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_stat           = '0;
        o_stat.in_valid  = i_s_tvalid;
        o_stat.in_zero   = (in_units == '0);
        o_stat.in_free   = (in_op == OP_FREE);
        o_stat.scan_done = scan_done;
        o_stat.alloc_hit = alloc_hit;
        o_stat.fill_ok   = i_cmd.fill && (fill_free_slot || (!fill_here && room));
        o_stat.fill_fail = i_cmd.fill && !fill_here && !room;
        o_stat.out_free  = out_free;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = {r_cfg_start, r_cfg_total};
        if (cfg_hit) begin
            ram_we    = 1'b1;
            ram_wdata = {cfg_start_n, cfg_total_n};
        end else if (i_cmd.init) begin
            ram_we = 1'b1;
        end else if (alloc_hit && (rd_len != r_units)) begin
            // A larger fit is shrunk from its low end.
            ram_we    = 1'b1;
            ram_waddr = r_ev_idx;
            ram_wdata = {sat_start, rd_len - r_units};
        end else if (i_cmd.write_back) begin
            ram_we    = 1'b1;
            ram_waddr = r_slot;
            ram_wdata = {r_addr, r_acc};
        end
    end

    ffrm_ram #(.W(2 * UB), .D(TABLE_SLOTS), .AW(IW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start <= '0;
            r_cfg_total <= '0;
            r_valid     <= TABLE_SLOTS'(1);
            r_siu       <= CW'(1);
            r_idx       <= '0;
            r_ev        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_hit) begin
                r_cfg_start <= cfg_start_n;
                r_cfg_total <= cfg_total_n;
                r_valid     <= TABLE_SLOTS'(1);
                r_siu       <= CW'(1);
            end

            if (i_cmd.accept && i_s_tvalid) begin
                r_addr   <= in_addr;
                r_units  <= in_units;
                r_acc    <= in_units;
                r_base   <= '0;
                r_status <= (in_units == '0) ? ST_ZERO_UNITS : ST_OK;
            end

            // Read issue runs one slot ahead of evaluation.
            if (scan_act) begin
                if (scan_done || alloc_hit) begin
                    r_idx <= '0;
                    r_ev  <= 1'b0;
                end else if (r_idx < r_siu) begin
                    r_ev     <= 1'b1;
                    r_ev_idx <= r_idx[IW-1:0];
                    r_idx    <= r_idx + CW'(1);
                end else begin
                    r_ev <= 1'b0;
                end
            end

            if (i_cmd.alloc_scan && scan_done) begin
                r_status <= ST_NO_SPACE;
            end
            if (alloc_hit) begin
                r_base <= rd_start;
                if (rd_len == r_units) begin
                    r_valid[r_ev_idx] <= 1'b0;
                end
            end

            if (i_cmd.fill) begin
                if (fill_free_slot) begin
                    r_slot                   <= r_idx[IW-1:0];
                    r_valid[r_idx[IW-1:0]]   <= 1'b1;
                    r_idx                    <= '0;
                end else if (fill_here) begin
                    r_idx <= r_idx + CW'(1);
                end else begin
                    r_idx <= '0;
                    if (room) begin
                        r_slot                 <= r_siu[IW-1:0];
                        r_valid[r_siu[IW-1:0]] <= 1'b1;
                        r_siu                  <= r_siu + CW'(1);
                    end else begin
                        r_status <= ST_TABLE_FULL;
                    end
                end
            end

            // A left neighbour absorbs the new extent and becomes the slot.
            if (left_hit) begin
                r_valid[r_slot] <= 1'b0;
                r_slot          <= r_ev_idx;
                r_addr          <= rd_start;
                r_units         <= sat_len;
                r_acc           <= sat_len;
            end
            if (right_hit) begin
                r_acc             <= sat_len;
                r_valid[r_ev_idx] <= 1'b0;
            end

            if (i_cmd.finish && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_base   <= FIELD_W'(r_base);
                r_out_status <= r_status;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - FIELD_W - STATUS_W){1'b0}},
                         r_out_status, r_out_base};
endmodule
